FILE: rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by modexp_mulmod and modular_exponentiation_top.
`timescale 1ns / 1ps

package modexp_pkg;

	// External field width of every number on the ports.
	localparam int FIELD_W = 64;
	// Working width of the arithmetic; only the low WIDTH bits of a field are used.
	localparam int WIDTH = 64;
	// Bit counter of one serial multiply pass.
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	typedef struct packed {
		logic [FIELD_W-1:0] base;
		logic [FIELD_W-1:0] exponent;
	} operands_t;

	typedef struct packed {
		logic [FIELD_W-1:0] power;
		logic               bad_modulus;
	} result_t;

	// Request to the shared modular multiplier: prod = addend * mult mod m,
	// with addend already below m.
	typedef struct packed {
		logic             go;
		logic [WIDTH-1:0] addend;
		logic [WIDTH-1:0] mult;
	} mm_req_t;

	typedef struct packed {
		logic             done;
		logic [WIDTH-1:0] prod;
	} mm_rsp_t;

endpackage

FILE: rtl/modexp_mulmod.sv
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
// Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_mulmod import modexp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] m,
	input  mm_req_t          req,
	output mm_rsp_t          rsp
);

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] addend_q;
	logic [WIDTH-1:0] mult_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+1:0] m1;
	logic [WIDTH+1:0] m2;
	logic [WIDTH+1:0] nxt;

	// double the partial result, add the addend on a set bit, fold back below m
	always_comb begin
		m1  = {2'b00, m};
		m2  = {1'b0, m, 1'b0};
		sum = {1'b0, acc_q, 1'b0}
			+ (mult_q[WIDTH-1] ? {2'b00, addend_q} : {(WIDTH+2){1'b0}});
		if (sum >= m2) begin
			nxt = sum - m2;
		end else if (sum >= m1) begin
			nxt = sum - m1;
		end else begin
			nxt = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			acc_q    <= '0;
			addend_q <= req.addend;
			mult_q   <= req.mult;
		end else if (busy_q) begin
			acc_q  <= nxt[WIDTH-1:0];
			mult_q <= {mult_q[WIDTH-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	a_no_go_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q) else $error("multiplier restarted mid-pass");

	a_done_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q)) else $error("done without a pass");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q || done_q) |-> (acc_q < m)) else $error("partial result not reduced");

endmodule

FILE: rtl/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: config register, sequencer
// and result register. Depends on modexp_pkg and modexp_mulmod.
`timescale 1ns / 1ps

// Channel     Ports                    Handshake
// ----------  -----------------------  ------------------------------------------
// command     start, busy, operands    transaction taken when start && !busy
// result      done, result             one-cycle strobe, receiver cannot stall
// config      cfg_we, cfg_data         modulus written when cfg_we, no wait
//
// Right-to-left square and multiply. All modular products go through one
// bit-serial multiplier. A transaction costs one reduction of the base, then
// for each exponent bit up to the top set bit a multiply when the bit is set
// and a square when higher bits remain. Zero modulus or zero exponent answers
// in the next cycle without raising busy. busy stays high for the whole of
// every other transaction; results appear on done for exactly one cycle.
// Reset returns the modulus to 1 and the sequencer to idle; no memory needs
// clearing.

module modular_exponentiation_top import modexp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  operands_t          operands,
	output logic               done,
	output result_t            result,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_BIT  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_SQR  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] run_q;
	logic [WIDTH-1:0] acc_q;
	logic             done_q;
	result_t          result_q;

	mm_req_t          req;
	mm_rsp_t          rsp;

	logic             accept;
	logic [WIDTH-1:0] in_base;
	logic [WIDTH-1:0] in_exp;
	logic [WIDTH-1:0] one_red;
	logic             more_bits;

	assign accept    = start && (state_q == ST_IDLE);
	assign in_base   = operands.base[WIDTH-1:0];
	assign in_exp    = operands.exponent[WIDTH-1:0];
	// 1 reduced by the modulus: zero when the modulus is one
	assign one_red   = (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);
	// bits still above the current one decide whether another square is due
	assign more_bits = (exp_q[WIDTH-1:1] != '0);

	// Modulus register: to be written only while idle; the user must keep to this, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= WIDTH'(1);
		end else if (cfg_we) begin
			mod_q <= cfg_data[WIDTH-1:0];
		end
	end

	// Issue work to the shared multiplier.
	always_comb begin
		req.go     = 1'b0;
		req.addend = acc_q;
		req.mult   = run_q;
		case (state_q)
			ST_IDLE: begin
				// reduce the base first: base * (1 mod m) mod m
				req.go     = accept && (mod_q != '0) && (in_exp != '0);
				req.addend = one_red;
				req.mult   = in_base;
			end
			ST_BIT: begin
				// multiply on a set bit, otherwise square straight away
				req.go     = 1'b1;
				req.addend = exp_q[0] ? acc_q : run_q;
				req.mult   = run_q;
			end
			ST_MUL: begin
				req.go     = rsp.done && more_bits;
				req.addend = run_q;
				req.mult   = run_q;
			end
			default: begin
				req.go = 1'b0;
			end
		endcase
	end

	modexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.m      (mod_q),
		.req    (req),
		.rsp    (rsp)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if ((mod_q == '0) || (in_exp == '0)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (rsp.done) begin
						state_q <= ST_BIT;
					end
				end
				ST_BIT: begin
					state_q <= exp_q[0] ? ST_MUL : ST_SQR;
				end
				ST_MUL: begin
					if (rsp.done) begin
						if (more_bits) begin
							state_q <= ST_SQR;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				ST_SQR: begin
					if (rsp.done) begin
						state_q <= ST_BIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: exponent shift, running power, accumulator, result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					exp_q <= in_exp;
					if (mod_q == '0) begin
						result_q.power       <= '0;
						result_q.bad_modulus <= 1'b1;
					end else begin
						// zero exponent gives 1 without reduction
						result_q.power       <= FIELD_W'(1);
						result_q.bad_modulus <= 1'b0;
					end
				end
			end
			ST_RED: begin
				if (rsp.done) begin
					run_q <= rsp.prod;
					acc_q <= one_red;
				end
			end
			ST_MUL: begin
				if (rsp.done) begin
					acc_q                <= rsp.prod;
					result_q.power       <= FIELD_W'(rsp.prod);
					result_q.bad_modulus <= 1'b0;
				end
			end
			ST_SQR: begin
				if (rsp.done) begin
					run_q <= rsp.prod;
					exp_q <= {1'b0, exp_q[WIDTH-1:1]};
				end
			end
			default: begin
				exp_q <= exp_q;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_go_only_when_issuing: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> (state_q == ST_IDLE || state_q == ST_BIT || state_q == ST_MUL))
		else $error("multiplier started from a waiting state");

	a_rsp_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier answered while nothing pending");

	a_bad_modulus_zero_power: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.bad_modulus) |-> (result_q.power == '0))
		else $error("bad modulus with nonzero power");

	a_square_only_with_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIT) |-> (exp_q != '0))
		else $error("bit step with exhausted exponent");

endmodule

FILE: tb/modexp_checker.sv
// Scoreboard for modular_exponentiation_top: tracks the modulus, predicts each power.
// Depends on modexp_pkg; instantiated by tb_modular_exponentiation_top next to the block.
`timescale 1ns / 1ps

module modexp_checker import modexp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  operands_t          operands,
	input  logic               done,
	input  result_t            result,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_data,
	output int unsigned        mismatches,
	output int unsigned        outstanding
);

	logic [FIELD_W-1:0] modulus_shadow;
	result_t            expected_powers[$];
	int unsigned        fail_tally;

	// Exact product then remainder; same residue as a reduce-first multiply.
	function automatic logic [FIELD_W-1:0] mod_product(input logic [FIELD_W-1:0] x,
		input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] m);
		logic [2*FIELD_W-1:0] wide;
		wide = {{FIELD_W{1'b0}}, x} * {{FIELD_W{1'b0}}, y};
		wide = wide % {{FIELD_W{1'b0}}, m};
		return wide[FIELD_W-1:0];
	endfunction

	function automatic result_t predict_power(input logic [FIELD_W-1:0] b,
		input logic [FIELD_W-1:0] e, input logic [FIELD_W-1:0] m);
		logic [FIELD_W-1:0] mask, mm, sq, ex, acc;
		result_t r;
		mask = {FIELD_W{1'b1}} >> (FIELD_W - WIDTH);
		mm = m & mask;
		sq = b & mask;
		ex = e & mask;
		acc = FIELD_W'(1);
		r.power = '0;
		r.bad_modulus = 1'b1;
		if (mm == 0)
			return r;
		// right to left: multiply on set bits, square every step
		while (ex != 0) begin
			if (ex[0])
				acc = mod_product(acc, sq, mm);
			sq = mod_product(sq, sq, mm);
			ex = ex >> 1;
		end
		r.power = acc & mask;
		r.bad_modulus = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			modulus_shadow = FIELD_W'(1);
			expected_powers.delete();
			fail_tally = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (expected_powers.size() == 0) begin
					fail_tally++;
					$display("%0t: unexpected result power=%h bad_modulus=%b",
						$time, result.power, result.bad_modulus);
				end else begin
					want = expected_powers.pop_front();
					if (result.power !== want.power) begin
						fail_tally++;
						$display("%0t: power expected %h actual %h",
							$time, want.power, result.power);
					end
					if (result.bad_modulus !== want.bad_modulus) begin
						fail_tally++;
						$display("%0t: bad_modulus expected %b actual %b",
							$time, want.bad_modulus, result.bad_modulus);
					end
				end
			end
			// predict with the modulus in force before any write at this edge
			if (start && !busy)
				expected_powers.push_back(predict_power(operands.base,
					operands.exponent, modulus_shadow));
			if (cfg_we)
				modulus_shadow = cfg_data;
			mismatches <= fail_tally;
			outstanding <= expected_powers.size();
		end
	end

endmodule

FILE: tb/tb_modular_exponentiation_top.sv
// Stimulus and verdict for modular_exponentiation_top; checking lives in modexp_checker.
// Depends on modexp_pkg, modexp_checker and the RTL of the block.
`timescale 1ns / 1ps

module tb_modular_exponentiation_top;
	import modexp_pkg::*;

	// Limit on the whole run; allows several times what the full run needs.
	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	localparam int unsigned ITEMS_PER_GROUP = 9;
	localparam int unsigned GROUPS_PER_PHASE = 3;
	localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	operands_t          operands;
	logic               done;
	result_t            result;
	logic               cfg_we;
	logic [FIELD_W-1:0] cfg_data;
	int unsigned        mismatches;
	int unsigned        outstanding;
	int unsigned        cycle_count;

	modular_exponentiation_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	modexp_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operands    (operands),
		.done        (done),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("modular_exponentiation_top verification failed");
			$finish;
		end
	end

	function automatic logic [FIELD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Mix of degenerate, tiny, 32-bit and full-width moduli.
	function automatic logic [FIELD_W-1:0] pick_modulus();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 16)
			return FIELD_W'(1);
		if (roll < 35)
			return FIELD_W'($urandom_range(2, 255));
		if (roll < 55)
			return {32'd0, $urandom};
		return rand_word() | {1'b1, {(FIELD_W-1){1'b0}}};
	endfunction

	function automatic logic [FIELD_W-1:0] pick_base();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 16)
			return FIELD_W'(1);
		if (roll < 26)
			return ALL_ONES;
		if (roll < 55)
			return FIELD_W'($urandom_range(0, 65535));
		return rand_word();
	endfunction

	// Narrow exponents keep most transactions short; full ones reach the top bits.
	function automatic logic [FIELD_W-1:0] pick_exponent();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 14)
			return ALL_ONES;
		if (roll < 60)
			return FIELD_W'($urandom_range(1, 65535));
		return rand_word();
	endfunction

	// Hold off a random number of cycles, then present one transaction and
	// keep it up until the block takes it. start stays high on return so a
	// back-to-back transaction never drops and raises it in the same step.
	task automatic send_operands(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e,
		input int unsigned idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operands.base <= b;
		operands.exponent <= e;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// Drop start and wait until every predicted result is back and the block is idle.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0 || busy !== 1'b0);
	endtask

	// Registers may only change while idle, so drain first.
	task automatic write_modulus(input logic [FIELD_W-1:0] m);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned idle_pct;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset modulus of 1: zero exponent still gives 1 unreduced.
		idle_pct = 31;
		send_operands(64'd5, 64'd0, idle_pct);
		send_operands(64'd5, 64'd3, idle_pct);

		// Zero modulus: error flag and zero power, whatever the exponent.
		write_modulus('0);
		send_operands(64'd7, 64'd5, idle_pct);
		send_operands(64'd0, 64'd0, idle_pct);
		send_operands(ALL_ONES, ALL_ONES, idle_pct);

		// Largest modulus: widest residues, base equal to modulus, longest exponent.
		write_modulus(ALL_ONES);
		send_operands(ALL_ONES, ALL_ONES, idle_pct);
		send_operands(ALL_ONES, 64'd1, idle_pct);
		send_operands(64'd0, 64'd0, idle_pct);
		send_operands(64'd0, 64'd5, idle_pct);
		send_operands(64'd2, 64'd63, idle_pct);
		send_operands(64'd2, 64'd64, idle_pct);
		send_operands(ALL_ONES - 1, 64'd2, idle_pct);

		// Smallest nontrivial modulus with an unreduced base.
		write_modulus(64'd2);
		send_operands(64'd3, ALL_ONES, idle_pct);
		send_operands(ALL_ONES, 64'd2, idle_pct);
		send_operands(64'd4, 64'd1, idle_pct);

		// Prime modulus, mostly well below the base.
		write_modulus(64'd1_000_000_007);
		send_operands(ALL_ONES, 64'd12345, idle_pct);
		send_operands(64'h8000_0000_0000_0001, 64'd1, idle_pct);
		send_operands(64'd2, 64'd1_000_000_006, idle_pct);

		// Random part: three idling regimes, each with several moduli.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 31 : (phase == 1) ? 78 : 0;
			for (int group = 0; group < GROUPS_PER_PHASE; group++) begin
				write_modulus(pick_modulus());
				for (int n = 0; n < ITEMS_PER_GROUP; n++)
					send_operands(pick_base(), pick_exponent(), idle_pct);
			end
		end

		// Wait out every result, then a short tail to catch any stray strobe.
		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("modular_exponentiation_top verification clean");
		end else begin
			$display("modular_exponentiation_top verification failed");
		end
		$finish;
	end

endmodule
